@@ rtl/core/yslc_pkg.sv @@
// Package for the yaw steering length controller.
// Holds widths, codes, sequencer enums and saturation helpers; no dependencies.
package yslc_pkg;

    localparam int DATA_W      = 32;              // Q16.16 data words
    localparam int WEIGHT_BITS = 16;              // weight fraction bits
    localparam int WEIGHT_W    = WEIGHT_BITS + 1; // weight register width
    localparam int BAND_W      = 31;
    localparam int MCAND_W     = DATA_W + 1;      // difference of two data words
    localparam int ACC_W       = 66;              // holds any product plus addend
    localparam int MPLR_W      = 32;
    localparam int CNT_W       = 6;
    localparam int DIR_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;              // 66 bits of fields, padded to bytes

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_BITS;

    typedef enum logic [DIR_W-1:0] {
        DIR_PARAM_ERROR = 2'd0,
        DIR_RIGHT       = 2'd1,
        DIR_LEFT        = 2'd2,
        DIR_NONE        = 2'd3
    } t_dir;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA_YAW   = 3'd0,
        CFG_ALPHA_DELTA = 3'd1,
        CFG_GAIN        = 3'd2,
        CFG_ORIGIN      = 3'd3,
        CFG_YAW_DB      = 3'd4,
        CFG_CORR_DB     = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIN,
        ST_POST,
        ST_LEN
    } t_state;

    typedef enum logic [1:0] {
        PH_YAW,
        PH_GAIN,
        PH_CORR
    } t_phase;

    // Clamp a wide signed value to 32 bits.
    function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-DATA_W:0] hi;
        hi = v[ACC_W-1:DATA_W-1];
        if (hi == '0 || hi == '1) begin
            sat_acc = v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            sat_acc = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat_acc = {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    // Clamp a 33-bit signed sum to 32 bits.
    function automatic logic signed [DATA_W-1:0] sat_33(input logic signed [DATA_W:0] v);
        if (v[DATA_W] == v[DATA_W-1]) begin
            sat_33 = v[DATA_W-1:0];
        end else if (v[DATA_W]) begin
            sat_33 = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat_33 = {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    // Magnitude of a 32-bit signed word, as unsigned 32 bits (exact for the minimum).
    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
        mag32 = v[DATA_W-1] ? DATA_W'(-v) : v;
    endfunction

endpackage

@@ rtl/core/yaw_steering_length_control_top.sv @@
// Yaw steering length controller: top level with bit-serial multiply sequencer.
// Depends on yslc_pkg.
//
//  channel   | direction | handshake                    | payload (low bit up)
//  ----------+-----------+------------------------------+-----------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | yaw_error[31:0]
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | left[31:0] right[63:32] dir[65:64]
//  cfg       | in        | i_cfg_we, no wait            | i_cfg_idx selects, i_cfg_data
//
// Each item runs three serial multiplies through one shared shift-add unit (one
// multiplier bit per cycle), each followed by the finishing and post steps
// (ST_FIN, ST_POST), then the length step (ST_LEN). The next input transfer is
// taken only once the sequencer is back in idle, so one item is in work at a time.
// With a weight above one the multiplies are skipped and the length step follows.
// i_rst_n is synchronous, active low; it clears filters, config and valids.
// A result that waits on m_axis_tready does not block the next input transfer;
// only the final length step stalls until the output register is free.
module yaw_steering_length_control_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [yslc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // yaw_error
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // left_len, right_len, direction, zero pad
    output logic [yslc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                 i_cfg_we,
    input  logic [yslc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [yslc_pkg::DATA_W-1:0]          i_cfg_data
);
    import yslc_pkg::*;

    // configuration
    logic [WEIGHT_W-1:0]      r_alpha_yaw, r_alpha_delta;
    logic signed [DATA_W-1:0] r_gain, r_origin;
    logic [BAND_W-1:0]        r_yaw_db, r_corr_db;

    // control and filter state
    t_state                   r_state, n_state;
    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_yf, n_yf, r_cf, n_cf;

    // datapath
    t_phase                    r_phase, n_phase;
    logic                      r_perr, n_perr;
    logic                      r_signed, n_signed;
    logic                      r_first, n_first;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [MPLR_W-1:0]         r_mplr, n_mplr;
    logic signed [MCAND_W-1:0] r_mcand, n_mcand;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic signed [DATA_W-1:0]  r_res, n_res;
    logic signed [DATA_W-1:0]  r_left, n_left, r_right, n_right;
    t_dir                      r_dir, n_dir;

    // combinational helpers
    logic signed [ACC_W-1:0]   mcand_ext, acc_sh, addend, sum, shifted;
    logic signed [DATA_W-1:0]  x_in, gated, half, lft, rgt;
    logic signed [DATA_W:0]    sum_p, sum_m;
    logic                      in_xfer, out_free, yf_zero;
    t_dir                      dir_c;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign x_in          = s_axis_tdata[DATA_W-1:0];

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2*DATA_W - DIR_W){1'b0}}, r_dir, r_right, r_left};

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_yaw   <= WEIGHT_ONE;
            r_alpha_delta <= WEIGHT_ONE;
            r_gain        <= DATA_W'(1) << FRAC_BITS;
            r_origin      <= '0;
            r_yaw_db      <= '0;
            r_corr_db     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ALPHA_YAW:   r_alpha_yaw   <= i_cfg_data[WEIGHT_W-1:0];
                CFG_ALPHA_DELTA: r_alpha_delta <= i_cfg_data[WEIGHT_W-1:0];
                CFG_GAIN:        r_gain        <= i_cfg_data;
                CFG_ORIGIN:      r_origin      <= i_cfg_data;
                CFG_YAW_DB:      r_yaw_db      <= i_cfg_data[BAND_W-1:0];
                CFG_CORR_DB:     r_corr_db     <= i_cfg_data[BAND_W-1:0];
                default: ;
            endcase
        end
    end

    // one multiplier bit per cycle, MSB first: acc = 2*acc +/- bit*mcand
    assign mcand_ext = ACC_W'(r_mcand);
    assign acc_sh    = r_acc <<< 1;

    // finishing: for the averages add the f*2^16 term, then shift and clamp
    assign addend  = (r_phase == PH_YAW)  ? (ACC_W'(r_yf) <<< WEIGHT_BITS) :
                     (r_phase == PH_CORR) ? (ACC_W'(r_cf) <<< WEIGHT_BITS) : '0;
    assign sum     = r_acc + addend;
    assign shifted = (r_phase == PH_GAIN) ? (sum >>> FRAC_BITS) : (sum >>> WEIGHT_BITS);

    // dead band on the freshly clamped filter value
    always_comb begin
        if (r_phase == PH_YAW) begin
            gated = (mag32(r_res) < {1'b0, r_yaw_db}) ? '0 : r_res;
        end else begin
            gated = ((mag32(r_res) < {1'b0, r_corr_db}) || r_yf == '0) ? '0 : r_res;
        end
    end

    // lengths
    assign yf_zero = (r_yf == '0);
    assign half    = r_cf >>> 1;
    assign sum_p   = (DATA_W+1)'(r_origin) + (DATA_W+1)'(half);
    assign sum_m   = (DATA_W+1)'(r_origin) - (DATA_W+1)'(half);

    always_comb begin
        if (r_yf[DATA_W-1]) begin
            lft   = sat_33(sum_p);
            rgt   = sat_33(sum_m);
            dir_c = DIR_RIGHT;
        end else if (!yf_zero) begin
            lft   = sat_33(sum_m);
            rgt   = sat_33(sum_p);
            dir_c = DIR_LEFT;
        end else begin
            lft   = r_origin;
            rgt   = r_origin;
            dir_c = DIR_NONE;
        end
    end

    // sequencer: next state and datapath loads
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_yf        = r_yf;
        n_cf        = r_cf;
        n_phase     = r_phase;
        n_perr      = r_perr;
        n_signed    = r_signed;
        n_first     = r_first;
        n_cnt       = r_cnt;
        n_mplr      = r_mplr;
        n_mcand     = r_mcand;
        n_acc       = r_acc;
        n_res       = r_res;
        n_left      = r_left;
        n_right     = r_right;
        n_dir       = r_dir;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_perr = (r_alpha_yaw > WEIGHT_ONE) || (r_alpha_delta > WEIGHT_ONE);
                    if ((r_alpha_yaw > WEIGHT_ONE) || (r_alpha_delta > WEIGHT_ONE)) begin
                        n_state = ST_LEN;
                    end else begin
                        // yaw average: f*2^16 + w*(x - f)
                        n_mcand  = MCAND_W'(x_in) - MCAND_W'(r_yf);
                        n_mplr   = {r_alpha_yaw, {(MPLR_W-WEIGHT_W){1'b0}}};
                        n_cnt    = CNT_W'(WEIGHT_W);
                        n_signed = 1'b0;
                        n_first  = 1'b1;
                        n_acc    = '0;
                        n_phase  = PH_YAW;
                        n_state  = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (r_mplr[MPLR_W-1]) begin
                    n_acc = (r_first && r_signed) ? acc_sh - mcand_ext : acc_sh + mcand_ext;
                end else begin
                    n_acc = acc_sh;
                end
                n_mplr  = r_mplr << 1;
                n_first = 1'b0;
                n_cnt   = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_res   = sat_acc(shifted);
                n_state = ST_POST;
            end
            ST_POST: begin
                unique case (r_phase)
                    PH_YAW: begin
                        n_yf     = gated;
                        n_mcand  = MCAND_W'(gated);
                        n_mplr   = r_gain;
                        n_cnt    = CNT_W'(MPLR_W);
                        n_signed = 1'b1;
                        n_first  = 1'b1;
                        n_acc    = '0;
                        n_phase  = PH_GAIN;
                        n_state  = ST_MUL;
                    end
                    PH_GAIN: begin
                        n_mcand  = MCAND_W'(r_res) - MCAND_W'(r_cf);
                        n_mplr   = {r_alpha_delta, {(MPLR_W-WEIGHT_W){1'b0}}};
                        n_cnt    = CNT_W'(WEIGHT_W);
                        n_signed = 1'b0;
                        n_first  = 1'b1;
                        n_acc    = '0;
                        n_phase  = PH_CORR;
                        n_state  = ST_MUL;
                    end
                    PH_CORR: begin
                        n_cf    = gated;
                        n_state = ST_LEN;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_LEN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_left      = r_perr ? '0 : lft;
                    n_right     = r_perr ? '0 : rgt;
                    n_dir       = r_perr ? DIR_PARAM_ERROR : dir_c;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_yf        <= '0;
            r_cf        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_yf        <= n_yf;
            r_cf        <= n_cf;
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        r_phase  <= n_phase;
        r_perr   <= n_perr;
        r_signed <= n_signed;
        r_first  <= n_first;
        r_cnt    <= n_cnt;
        r_mplr   <= n_mplr;
        r_mcand  <= n_mcand;
        r_acc    <= n_acc;
        r_res    <= n_res;
        r_left   <= n_left;
        r_right  <= n_right;
        r_dir    <= n_dir;
    end

endmodule

@@ rtl/core/yslc_checker.sv @@
// Port-level checker for the yaw steering length controller, bound to the top level.
// Depends on yslc_pkg and yaw_steering_length_control_top.
module yslc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [yslc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import yslc_pkg::*;

    // no result right after reset
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // weight error reports zero lengths
    a_perr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[65:64] == DIR_PARAM_ERROR |-> m_axis_tdata[63:0] == '0)
        else $error("parameter error with nonzero lengths");

    // no turn means both sides equal
    a_none_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[65:64] == DIR_NONE |->
        m_axis_tdata[31:0] == m_axis_tdata[63:32])
        else $error("no turn with unequal lengths");

endmodule

bind yaw_steering_length_control_top yslc_checker u_yslc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ verif/tb_yaw_steering_length_control_top.sv @@
// Self-checking bench for yaw_steering_length_control_top: directed and random yaw streams,
// config sweeps and random stalls on both stream sides. Depends on yslc_pkg and the RTL.
module tb_yaw_steering_length_control_top;
    import yslc_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int ONE_Q     = 1 << FRAC_BITS;          // 1.0 in Q16.16
    localparam int CFG_LAST  = CFG_CORR_DB;             // highest decoded register index
    localparam int CFG_SLOTS = 1 << CFG_IDX_W;          // index space of the write port
    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_TOP = {WEIGHT_W{1'b1}};

    // One expected output transfer: lengths and turn direction.
    typedef struct packed {
        logic signed [DATA_W-1:0] left;
        logic signed [DATA_W-1:0] right;
        t_dir                     dir;
    } t_steer_cmd;

    // ---------------------------------------------------------------------------------
    // DUT ports; every input has a known value from time zero
    // ---------------------------------------------------------------------------------
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // yaw_error[31:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // left[31:0] right[63:32] dir[65:64] pad
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [DATA_W-1:0]      i_cfg_data    = '0;

    // ---------------------------------------------------------------------------------
    // Shadow copy of the controller: config registers and the two filter states
    // ---------------------------------------------------------------------------------
    logic [WEIGHT_W-1:0]      cfg_alpha_yaw   = WEIGHT_ONE;
    logic [WEIGHT_W-1:0]      cfg_alpha_delta = WEIGHT_ONE;
    logic signed [DATA_W-1:0] cfg_gain        = ONE_Q;
    logic signed [DATA_W-1:0] cfg_origin      = '0;
    logic [BAND_W-1:0]        cfg_yaw_band    = '0;
    logic [BAND_W-1:0]        cfg_corr_band   = '0;
    logic signed [DATA_W-1:0] yaw_filt        = '0;
    logic signed [DATA_W-1:0] corr_filt       = '0;

    t_steer_cmd               expected_cmds[$];   // oldest first
    t_steer_cmd               oldest_cmd;
    int                       fail_count      = 0;
    bit                       sender_idle     = 1'b1;  // random gaps on s_axis
    bit                       sink_stall      = 1'b1;  // random back-pressure on m_axis
    logic signed [DATA_W-1:0] last_yaw        = '0;

    yaw_steering_length_control_top #(
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sink side: ready low in roughly a quarter of the cycles while stalling is on.
    always @(negedge i_clk) begin
        m_axis_tready <= !sink_stall || ($urandom_range(99) >= 25);
    end

    // ---------------------------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------------------------
    function automatic logic signed [DATA_W-1:0] clamp32(input longint signed v);
        if (v > longint'(Q_MAX)) return Q_MAX;
        if (v < longint'(Q_MIN)) return Q_MIN;
        return v[DATA_W-1:0];
    endfunction

    function automatic longint signed magnitude(input logic signed [DATA_W-1:0] v);
        longint signed w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    // Exponential average, exact product sum, floor shift by the weight fraction.
    function automatic logic signed [DATA_W-1:0] ema_step(input logic [WEIGHT_W-1:0] w,
                                                          input logic signed [DATA_W-1:0] x,
                                                          input logic signed [DATA_W-1:0] f);
        longint signed acc;
        acc = longint'(w) * longint'(x) + (longint'(WEIGHT_ONE) - longint'(w)) * longint'(f);
        return clamp32(acc >>> WEIGHT_BITS);
    endfunction

    // Advances the shadow filters by one sample and returns the command it produces.
    function automatic t_steer_cmd predict_steer(input logic signed [DATA_W-1:0] yaw);
        t_steer_cmd               cmd;
        logic signed [DATA_W-1:0] delta;
        logic signed [DATA_W-1:0] half;
        longint signed            left_w;
        longint signed            right_w;
        if (cfg_alpha_yaw > WEIGHT_ONE || cfg_alpha_delta > WEIGHT_ONE) begin
            // bad weight: filters frozen, lengths forced to zero
            cmd.left  = '0;
            cmd.right = '0;
            cmd.dir   = DIR_PARAM_ERROR;
            return cmd;
        end
        yaw_filt = ema_step(cfg_alpha_yaw, yaw, yaw_filt);
        if (magnitude(yaw_filt) < longint'(cfg_yaw_band)) yaw_filt = '0;
        delta     = clamp32((longint'(cfg_gain) * longint'(yaw_filt)) >>> FRAC_BITS);
        corr_filt = ema_step(cfg_alpha_delta, delta, corr_filt);
        if (magnitude(corr_filt) < longint'(cfg_corr_band) || yaw_filt == 0) corr_filt = '0;
        half = corr_filt >>> 1;
        if (yaw_filt < 0) begin
            left_w  = longint'(cfg_origin) + longint'(half);
            right_w = longint'(cfg_origin) - longint'(half);
            cmd.dir = DIR_RIGHT;
        end else if (yaw_filt > 0) begin
            left_w  = longint'(cfg_origin) - longint'(half);
            right_w = longint'(cfg_origin) + longint'(half);
            cmd.dir = DIR_LEFT;
        end else begin
            left_w  = cfg_origin;
            right_w = cfg_origin;
            cmd.dir = DIR_NONE;
        end
        cmd.left  = clamp32(left_w);
        cmd.right = clamp32(right_w);
        return cmd;
    endfunction

    // ---------------------------------------------------------------------------------
    // Result checker: every output transfer is matched against the oldest prediction
    // ---------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_cmds.size() == 0) begin
                $error("output transfer with no command expected: tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                oldest_cmd = expected_cmds.pop_front();
                if (m_axis_tdata[31:0] !== oldest_cmd.left) begin
                    $error("left_len mismatch: expected %0d, got %0d",
                           oldest_cmd.left, $signed(m_axis_tdata[31:0]));
                    fail_count++;
                end
                if (m_axis_tdata[63:32] !== oldest_cmd.right) begin
                    $error("right_len mismatch: expected %0d, got %0d",
                           oldest_cmd.right, $signed(m_axis_tdata[63:32]));
                    fail_count++;
                end
                if (m_axis_tdata[65:64] !== oldest_cmd.dir) begin
                    $error("direction mismatch: expected %0d, got %0d",
                           oldest_cmd.dir, m_axis_tdata[65:64]);
                    fail_count++;
                end
                if (m_axis_tdata[OUT_TDATA_W-1:66] !== '0) begin
                    $error("pad mismatch: expected 0, got %0h", m_axis_tdata[OUT_TDATA_W-1:66]);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Stream and config drivers (all entered and left on a falling edge)
    // ---------------------------------------------------------------------------------

    // One input transfer. tvalid is left high on return so back-to-back samples have
    // no bubble; the next caller decides at once whether to drop it.
    task automatic send_yaw(input logic signed [DATA_W-1:0] yaw);
        while (sender_idle && $urandom_range(99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= yaw;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_cmds.push_back(predict_steer(yaw));
        @(negedge i_clk);
    endtask

    // Stop sending and hold off until every predicted command has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Register write, only once the pipe is empty; the shadow copy follows it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        unique case (idx)
            CFG_ALPHA_YAW:   cfg_alpha_yaw   = data[WEIGHT_W-1:0];
            CFG_ALPHA_DELTA: cfg_alpha_delta = data[WEIGHT_W-1:0];
            CFG_GAIN:        cfg_gain        = data;
            CFG_ORIGIN:      cfg_origin      = data;
            CFG_YAW_DB:      cfg_yaw_band    = data[BAND_W-1:0];
            CFG_CORR_DB:     cfg_corr_band   = data[BAND_W-1:0];
            default: ;       // undecoded index, no effect
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Weight write with junk in the unused upper data bits.
    task automatic write_weight(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] w);
        write_reg(idx, {(DATA_W-WEIGHT_W)'($urandom()), w});
    endtask

    // ---------------------------------------------------------------------------------
    // Random value pickers
    // ---------------------------------------------------------------------------------
    function automatic logic [WEIGHT_W-1:0] pick_weight(input bit over_one);
        int unsigned roll;
        roll = $urandom_range(99);
        if (over_one) return WEIGHT_W'($urandom_range(int'(WEIGHT_ONE) + 1, int'(WEIGHT_TOP)));
        if (roll < 25) return WEIGHT_ONE;
        if (roll < 35) return '0;
        if (roll < 50) return WEIGHT_W'($urandom_range(1, 4096));
        return WEIGHT_W'($urandom_range(0, int'(WEIGHT_ONE)));
    endfunction

    function automatic logic [DATA_W-1:0] pick_band();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40) return '0;
        if (roll < 80) return $urandom_range(0, 8 * ONE_Q);
        if (roll < 90) return $urandom();          // bit 31 dropped by the register
        return {1'b0, {BAND_W{1'b1}}};
    endfunction

    function automatic logic [DATA_W-1:0] pick_gain();
        logic signed [DATA_W-1:0] g;
        if ($urandom_range(99) < 30) return $urandom();
        g = $urandom_range(0, 8 * ONE_Q);
        return $urandom_range(1) ? -g : g;
    endfunction

    // Mostly small angles and slow drift so filters and dead bands do real work.
    function automatic logic signed [DATA_W-1:0] next_yaw();
        int unsigned              roll;
        logic signed [DATA_W-1:0] yaw;
        roll = $urandom_range(99);
        if (roll < 45) begin
            yaw = $urandom_range(0, 30 * ONE_Q);
            if ($urandom_range(1)) yaw = -yaw;
        end else if (roll < 65) begin
            yaw = last_yaw + int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q;
        end else if (roll < 85) begin
            yaw = $urandom();
        end else begin
            case ($urandom_range(4))
                0:       yaw = Q_MAX;
                1:       yaw = Q_MIN;
                2:       yaw = '0;
                3:       yaw = 1;
                default: yaw = -1;
            endcase
        end
        last_yaw = yaw;
        return yaw;
    endfunction

    // ---------------------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------------------

    // Reset config: unity weights and gain, so lengths are plus/minus half the sample.
    task automatic test_default_config();
        send_yaw('0);
        send_yaw(1);
        send_yaw(-1);
        send_yaw(Q_MAX);
        send_yaw(Q_MIN);
        send_yaw(5 * ONE_Q);
        send_yaw(-5 * ONE_Q);
    endtask

    // Full-scale gain and origin: the correction and one of the two length sums clamp.
    task automatic test_saturation();
        write_reg(CFG_GAIN, Q_MAX);
        write_reg(CFG_ORIGIN, Q_MAX);
        send_yaw(Q_MAX);
        send_yaw(Q_MIN);
        write_reg(CFG_GAIN, Q_MIN);
        write_reg(CFG_ORIGIN, Q_MIN);
        send_yaw(Q_MAX);
        send_yaw(Q_MIN);
    endtask

    // Weight above one on either filter: zero lengths, state must survive untouched.
    task automatic test_param_error();
        write_reg(CFG_GAIN, ONE_Q);
        write_reg(CFG_ORIGIN, 10 * ONE_Q);
        write_weight(CFG_ALPHA_YAW, WEIGHT_ONE + WEIGHT_W'(1));
        send_yaw(7 * ONE_Q);
        send_yaw(Q_MIN);
        write_weight(CFG_ALPHA_YAW, WEIGHT_TOP);
        send_yaw(Q_MAX);
        write_weight(CFG_ALPHA_YAW, WEIGHT_ONE);
        write_weight(CFG_ALPHA_DELTA, WEIGHT_ONE + WEIGHT_W'(1));
        send_yaw(-3 * ONE_Q);
        write_weight(CFG_ALPHA_DELTA, WEIGHT_ONE);
        send_yaw(ONE_Q);
    endtask

    // Strict band compare on both sides, and correction band with a live yaw.
    task automatic test_dead_bands();
        write_reg(CFG_ORIGIN, 100 * ONE_Q);
        write_reg(CFG_YAW_DB, 2 * ONE_Q);
        send_yaw(2 * ONE_Q - 1);              // just inside: no turn
        send_yaw(2 * ONE_Q);                  // on the edge: passes
        send_yaw(-2 * ONE_Q);
        send_yaw(-2 * ONE_Q + 1);
        write_reg(CFG_CORR_DB, 3 * ONE_Q);
        send_yaw(2 * ONE_Q);                  // yaw live, correction held at zero
        send_yaw(8 * ONE_Q);
    endtask

    // Frozen yaw filter, half-weight correction filter, undecoded indexes.
    task automatic test_filter_weights();
        write_reg(CFG_YAW_DB, '0);
        write_reg(CFG_CORR_DB, '0);
        write_weight(CFG_ALPHA_DELTA, WEIGHT_ONE >> 1);
        write_weight(CFG_ALPHA_YAW, '0);
        send_yaw(20 * ONE_Q);                 // yaw filter holds its old value
        send_yaw(-20 * ONE_Q);
        for (int idx = CFG_LAST + 1; idx < CFG_SLOTS; idx++) begin
            write_reg(CFG_IDX_W'(idx), $urandom());
        end
        write_weight(CFG_ALPHA_YAW, WEIGHT_ONE >> 2);
        send_yaw(-20 * ONE_Q);
    endtask

    // New settings for one random run; the first two runs pin the register extremes.
    task automatic configure_run(input int run, input bit bad_weight);
        if (run == 0) begin
            write_weight(CFG_ALPHA_YAW, WEIGHT_W'(1));
            write_weight(CFG_ALPHA_DELTA, WEIGHT_ONE);
            write_reg(CFG_GAIN, Q_MIN);
            write_reg(CFG_ORIGIN, Q_MAX);
            write_reg(CFG_YAW_DB, '0);
            write_reg(CFG_CORR_DB, '0);
        end else if (run == 1) begin
            write_weight(CFG_ALPHA_YAW, WEIGHT_ONE);
            write_weight(CFG_ALPHA_DELTA, '0);
            write_reg(CFG_GAIN, Q_MAX);
            write_reg(CFG_ORIGIN, Q_MIN);
            write_reg(CFG_YAW_DB, {1'b0, {BAND_W{1'b1}}});
            write_reg(CFG_CORR_DB, {1'b1, {BAND_W{1'b1}}});
        end else begin
            write_weight(CFG_ALPHA_YAW, pick_weight(bad_weight && $urandom_range(1)));
            write_weight(CFG_ALPHA_DELTA, pick_weight(bad_weight));
            write_reg(CFG_GAIN, pick_gain());
            write_reg(CFG_ORIGIN, $urandom_range(1) ? $urandom()
                                                    : $urandom_range(0, 2000 * ONE_Q)
                                                      - 1000 * ONE_Q);
            write_reg(CFG_YAW_DB, pick_band());
            write_reg(CFG_CORR_DB, pick_band());
        end
    endtask

    // Runs of random samples under changing config; run 3 has no gaps and no stalls.
    task automatic test_random_runs();
        int  n_items;
        bit  bad_weight;
        for (int run = 0; run < 12; run++) begin
            bad_weight = (run % 6 == 5);
            configure_run(run, bad_weight);
            sender_idle = (run != 3);
            sink_stall  = (run != 3);
            n_items     = bad_weight ? 20 : 140;
            for (int i = 0; i < n_items; i++) begin
                // let the pipe run dry mid-run now and then
                if (run % 4 == 1 && i == n_items / 2) drain_results();
                send_yaw(next_yaw());
            end
        end
        sender_idle = 1'b1;
        sink_stall  = 1'b1;
    endtask

    // ---------------------------------------------------------------------------------
    // Sequence: reset once, directed checks, random runs, then wait for the tail
    // ---------------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_config();
        test_saturation();
        test_param_error();
        test_dead_bands();
        test_filter_weights();
        test_random_runs();

        drain_results();
        // wait on past the end of an item's run, so a stray extra transfer would be caught
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: stops a hung simulation and reports it as failed.
    initial begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ yaw_steering_length_control_top.f @@
rtl/core/yslc_pkg.sv
rtl/core/yaw_steering_length_control_top.sv
rtl/core/yslc_checker.sv
verif/tb_yaw_steering_length_control_top.sv
